// File: rtl/plateau_level_detector_assert.svh
// Assertion macros shared by the plateau level detector RTL.
`ifndef PLATEAU_LEVEL_DETECTOR_ASSERT_SVH
`define PLATEAU_LEVEL_DETECTOR_ASSERT_SVH

// Same-cycle implication, masked while reset is high.
`define PLD_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("plateau_level_detector: implication check failed");

// Next-cycle implication, checked during reset as well.
`define PLD_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("plateau_level_detector: next-cycle check failed");

`endif

// File: rtl/pld_pkg.sv
// Package with types, constants and register codes of the plateau level detector.
`timescale 1ns / 1ps

package pld_pkg;

   // default widths of the parameterised datapath
   localparam int SAMPLE_BITS_DEFAULT    = 16;
   localparam int RUN_COUNT_BITS_DEFAULT = 24;

   // fixed widths
   localparam int LEVELS         = 3;
   localparam int REF_BITS       = 16;
   localparam int HALF_BITS      = 15;
   localparam int MIN_BITS       = 24;
   localparam int SUM_BITS       = 40;
   localparam int NUM_BITS       = SUM_BITS + 8;
   localparam int MEAN_BITS      = 24;
   localparam int TALLY_BITS     = 32;
   localparam int QUEUE_DEPTH    = 4;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 24;

   localparam logic [1:0] LEVEL_UNSTABLE = 2'd3;

   localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REF_LEVEL_0      = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REF_LEVEL_1      = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REF_LEVEL_2      = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BAND_HALF_WIDTH  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STABLE_COUNT_MIN = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RANGE_FLOOR      = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RANGE_CEILING    = 3'd6;

   // sample classes
   typedef enum logic [1:0] {
      CLS_UNDER   = 2'd0,
      CLS_BAND    = 2'd1,
      CLS_OVER    = 2'd2,
      CLS_BETWEEN = 2'd3
   } class_type;

   typedef struct packed {
      logic [LEVELS-1:0][REF_BITS-1:0] ref_level;
      logic [HALF_BITS-1:0]            band_half_width;
      logic [MIN_BITS-1:0]             stable_count_min;
      logic [REF_BITS-1:0]             range_floor;
      logic [REF_BITS-1:0]             range_ceiling;
   } cfg_type;

   typedef struct packed {
      class_type  cls;
      logic [1:0] band;
      logic       last;
   } meta_type;

   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   typedef struct packed {
      logic dividing;
      logic emitting;
   } bk_status_type;

   typedef struct packed {
      logic                             status;
      logic [LEVELS-1:0]                done_flags;
      logic [LEVELS-1:0][MEAN_BITS-1:0] mean;
      logic [TALLY_BITS-1:0]            total_count;
      logic [TALLY_BITS-1:0]            under_range_count;
      logic [TALLY_BITS-1:0]            over_range_count;
   } rsp_type;

endpackage

// File: rtl/pld_queue.sv
// Short register queue between the classifying front and the run-tracking back.
`timescale 1ns / 1ps

module pld_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             valid,
   output logic             full
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    ent_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] fill_ff, fill_in;
   logic                do_push, do_pop;

   assign full    = (fill_ff == CNT_BITS'(DEPTH));
   assign valid   = (fill_ff != '0);
   assign do_push = push && !full;
   assign do_pop  = pop && valid;
   assign rdata   = ent_ff[rd_ptr_ff];

   // advance pointers with wrap, track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // store the entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         ent_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// File: rtl/pld_front.sv
// Front end: takes samples and sorts them against floor, bands and ceiling.
`timescale 1ns / 1ps

module pld_front #(
   parameter int SAMPLE_BITS = pld_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_last,
   input  pld_pkg::cfg_type              cfg,
   input  logic                          q_full,
   output logic                          q_push,
   output pld_pkg::meta_type             meta
);

   import pld_pkg::*;

   localparam int CMP_BITS = ((SAMPLE_BITS > REF_BITS + 1) ? SAMPLE_BITS : REF_BITS + 1) + 1;

   logic signed [CMP_BITS-1:0] x_ext;
   logic signed [CMP_BITS-1:0] half_ext;
   logic signed [CMP_BITS-1:0] floor_ext;
   logic signed [CMP_BITS-1:0] ceil_ext;
   logic signed [CMP_BITS-1:0] lo_ext [LEVELS];
   logic signed [CMP_BITS-1:0] hi_ext [LEVELS];
   logic [LEVELS-1:0]          in_band;
   logic                       under, over;

   // hold the sender off while the queue is full
   assign req_stall = q_full;
   assign q_push    = req_valid;

   assign x_ext     = CMP_BITS'(req_sample);
   assign half_ext  = CMP_BITS'($signed({1'b0, cfg.band_half_width}));
   assign floor_ext = CMP_BITS'($signed(cfg.range_floor));
   assign ceil_ext  = CMP_BITS'($signed(cfg.range_ceiling));

   // open interval test per band
   always_comb begin
      for (int k = 0; k < LEVELS; k++) begin
         lo_ext[k]  = CMP_BITS'($signed(cfg.ref_level[k])) - half_ext;
         hi_ext[k]  = CMP_BITS'($signed(cfg.ref_level[k])) + half_ext;
         in_band[k] = (x_ext > lo_ext[k]) && (x_ext < hi_ext[k]);
      end
   end

   assign under = (x_ext < floor_ext);
   assign over  = (x_ext > ceil_ext);

   // classify: floor first, then lowest band, then ceiling
   always_comb begin
      meta.last = req_last;
      meta.band = LEVEL_UNSTABLE;
      if (in_band[0]) begin
         meta.band = 2'd0;
      end else if (in_band[1]) begin
         meta.band = 2'd1;
      end else if (in_band[2]) begin
         meta.band = 2'd2;
      end
      if (under) begin
         meta.cls = CLS_UNDER;
      end else if (in_band != '0) begin
         meta.cls = CLS_BAND;
      end else if (over) begin
         meta.cls = CLS_OVER;
      end else begin
         meta.cls = CLS_BETWEEN;
      end
   end

endmodule

// File: rtl/pld_div.sv
// Restoring divider, one quotient bit a cycle, for the buffer-end means.
`timescale 1ns / 1ps

module pld_div #(
   parameter int DEN_BITS = pld_pkg::RUN_COUNT_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pld_pkg::div_ctl_type          ctl,
   input  logic [pld_pkg::NUM_BITS-1:0]  numer,
   input  logic [DEN_BITS-1:0]           denom,
   output logic [pld_pkg::NUM_BITS-1:0]  quotient,
   output pld_pkg::div_stat_type         stat
);

   import pld_pkg::*;

   localparam int STEP_BITS = $clog2(NUM_BITS + 1);

   logic [NUM_BITS-1:0]  num_ff, num_in;
   logic [DEN_BITS-1:0]  rem_ff, rem_in;
   logic [DEN_BITS-1:0]  den_ff, den_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DEN_BITS:0]    trial;
   logic [DEN_BITS:0]    diff;
   logic                 fits;

   assign trial = {rem_ff, num_ff[NUM_BITS-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = (trial >= {1'b0, den_ff});

   // load on start, then shift one quotient bit in per cycle
   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         num_in  = {num_ff[NUM_BITS-2:0], fits};
         rem_in  = fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (ctl.start) begin
         num_in  = numer;
         rem_in  = '0;
         den_in  = denom;
         step_in = STEP_BITS'(NUM_BITS);
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quotient  = num_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// File: rtl/pld_back.sv
// Back end: tracks runs, captures plateaus, keeps counters and builds the report.
`timescale 1ns / 1ps

module pld_back #(
   parameter int SAMPLE_BITS    = pld_pkg::SAMPLE_BITS_DEFAULT,
   parameter int RUN_COUNT_BITS = pld_pkg::RUN_COUNT_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pld_pkg::cfg_type              cfg,
   input  logic                          q_valid,
   input  logic signed [SAMPLE_BITS-1:0] q_sample,
   input  pld_pkg::meta_type             q_meta,
   output logic                          q_pop,
   output pld_pkg::div_ctl_type          div_ctl,
   output logic [pld_pkg::NUM_BITS-1:0]  div_numer,
   output logic [RUN_COUNT_BITS-1:0]     div_denom,
   input  logic [pld_pkg::NUM_BITS-1:0]  div_quotient,
   input  pld_pkg::div_stat_type         div_stat,
   output pld_pkg::bk_status_type        status,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output pld_pkg::rsp_type              rsp
);

   import pld_pkg::*;

   localparam int CMPW = (RUN_COUNT_BITS > MIN_BITS) ? RUN_COUNT_BITS : MIN_BITS;

   localparam logic [NUM_BITS-1:0]  MEAN_LIMIT = NUM_BITS'(1) << (MEAN_BITS - 1);
   localparam logic [MEAN_BITS-1:0] MEAN_MAG   = MEAN_BITS'(1) << (MEAN_BITS - 1);
   localparam logic [MEAN_BITS-1:0] MEAN_POS   = MEAN_MAG - 1'b1;

   typedef enum logic [2:0] {
      ST_RUN  = 3'b001,
      ST_DIV  = 3'b010,
      ST_EMIT = 3'b100
   } bk_state_type;

   bk_state_type              state_ff, state_in;
   logic [1:0]                cur_ff, cur_in;
   logic [RUN_COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic signed [SUM_BITS-1:0] sum_ff, sum_in;
   logic signed [SUM_BITS-1:0] cap_sum_ff [LEVELS];
   logic signed [SUM_BITS-1:0] cap_sum_in [LEVELS];
   logic [RUN_COUNT_BITS-1:0] cap_cnt_ff [LEVELS];
   logic [RUN_COUNT_BITS-1:0] cap_cnt_in [LEVELS];
   logic [LEVELS-1:0]         done_ff, done_in;
   logic [TALLY_BITS-1:0]     seen_ff, seen_in;
   logic [TALLY_BITS-1:0]     under_ff, under_in;
   logic [TALLY_BITS-1:0]     over_ff, over_in;
   logic [1:0]                idx_ff, idx_in;
   logic                      launched_ff, launched_in;
   logic [MEAN_BITS-1:0]      mean_ff [LEVELS];
   logic [MEAN_BITS-1:0]      mean_in [LEVELS];
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff, rsp_in;
   logic                      rsp_load;

   logic [CMPW-1:0]           min_ext;
   logic                      chk_old, chk_new, leave_run;
   logic signed [SUM_BITS:0]  sum_wide;
   logic signed [SUM_BITS-1:0] sum_acc;
   logic signed [SUM_BITS-1:0] sel_sum;
   logic [RUN_COUNT_BITS-1:0] sel_cnt;
   logic [SUM_BITS-1:0]       sel_mag;
   logic                      sel_ok;
   logic [MEAN_BITS-1:0]      q_sat;
   logic [MEAN_BITS-1:0]      mean_val;

   assign min_ext = CMPW'(cfg.stable_count_min);

   // saturating accumulation of the run sum
   assign sum_wide = (SUM_BITS + 1)'(sum_ff) + (SUM_BITS + 1)'(q_sample);
   always_comb begin
      if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
         sum_acc = sum_wide[SUM_BITS] ? SUM_MIN : SUM_MAX;
      end else begin
         sum_acc = sum_wide[SUM_BITS-1:0];
      end
   end

   // divider operands for the level being reported
   assign sel_sum   = cap_sum_ff[idx_ff];
   assign sel_cnt   = cap_cnt_ff[idx_ff];
   assign sel_ok    = done_ff[idx_ff] && (sel_cnt != '0);
   assign sel_mag   = sel_sum[SUM_BITS-1] ? SUM_BITS'(-sel_sum) : SUM_BITS'(sel_sum);
   assign div_numer = {sel_mag, 8'h00} + NUM_BITS'(sel_cnt >> 1);
   assign div_denom = sel_cnt;

   // round-to-nearest magnitude back to signed Q16.8 with saturation
   assign q_sat = (div_quotient > MEAN_LIMIT) ? MEAN_MAG : div_quotient[MEAN_BITS-1:0];
   always_comb begin
      if (!sel_ok) begin
         mean_val = '0;
      end else if (sel_sum[SUM_BITS-1]) begin
         mean_val = MEAN_BITS'(-q_sat);
      end else if (q_sat == MEAN_MAG) begin
         mean_val = MEAN_POS;
      end else begin
         mean_val = q_sat;
      end
   end

   assign chk_old = (cur_ff != LEVEL_UNSTABLE) && (CMPW'(cnt_ff) > min_ext);

   // sequence: run tracking, three divisions, then hand over the report
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      cnt_in       = cnt_ff;
      sum_in       = sum_ff;
      cap_sum_in   = cap_sum_ff;
      cap_cnt_in   = cap_cnt_ff;
      done_in      = done_ff;
      seen_in      = seen_ff;
      under_in     = under_ff;
      over_in      = over_ff;
      idx_in       = idx_ff;
      launched_in  = launched_ff;
      mean_in      = mean_ff;
      q_pop        = 1'b0;
      div_ctl      = '0;
      rsp_load     = 1'b0;
      leave_run    = 1'b0;
      chk_new      = 1'b0;
      case (state_ff)
         ST_RUN: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               seen_in = (&seen_ff) ? seen_ff : seen_ff + 1'b1;
               case (q_meta.cls)
                  CLS_UNDER: begin
                     leave_run = 1'b1;
                     under_in  = (&under_ff) ? under_ff : under_ff + 1'b1;
                  end
                  CLS_BAND: begin
                     if (cur_ff == q_meta.band) begin
                        if (!(&cnt_ff)) begin
                           cnt_in = cnt_ff + 1'b1;
                           sum_in = sum_acc;
                        end
                     end else begin
                        leave_run = 1'b1;
                        cur_in    = q_meta.band;
                        cnt_in    = RUN_COUNT_BITS'(1);
                        sum_in    = SUM_BITS'(q_sample);
                     end
                  end
                  CLS_OVER: begin
                     leave_run = 1'b1;
                     over_in   = (&over_ff) ? over_ff : over_ff + 1'b1;
                  end
                  default: begin
                     // between bands: drop to unstable
                     leave_run = 1'b1;
                     cur_in    = LEVEL_UNSTABLE;
                     cnt_in    = '0;
                     sum_in    = '0;
                  end
               endcase
               // capture the run that was left
               for (int k = 0; k < LEVELS; k++) begin
                  if (leave_run && chk_old && (cur_ff == 2'(k))) begin
                     cap_sum_in[k] = sum_ff;
                     cap_cnt_in[k] = cnt_ff;
                     done_in[k]    = 1'b1;
                  end
               end
               // buffer end: capture the open run too, then start the report
               if (q_meta.last) begin
                  chk_new = (cur_in != LEVEL_UNSTABLE) && (CMPW'(cnt_in) > min_ext);
                  for (int k = 0; k < LEVELS; k++) begin
                     if (chk_new && (cur_in == 2'(k))) begin
                        cap_sum_in[k] = sum_in;
                        cap_cnt_in[k] = cnt_in;
                        done_in[k]    = 1'b1;
                     end
                  end
                  state_in    = ST_DIV;
                  idx_in      = '0;
                  launched_in = 1'b0;
               end
            end
         end
         ST_DIV: begin
            if (!launched_ff) begin
               div_ctl.start = 1'b1;
               launched_in   = 1'b1;
            end else if (div_stat.done) begin
               mean_in[idx_ff] = mean_val;
               launched_in     = 1'b0;
               if (idx_ff == 2'(LEVELS - 1)) begin
                  state_in = ST_EMIT;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   // assemble the report
   always_comb begin
      rsp_in                   = rsp_ff;
      rsp_valid_in             = rsp_stall ? rsp_valid_ff : 1'b0;
      if (rsp_load) begin
         rsp_valid_in             = 1'b1;
         rsp_in.status            = (done_ff != '1);
         rsp_in.done_flags        = done_ff;
         for (int k = 0; k < LEVELS; k++) begin
            rsp_in.mean[k] = mean_ff[k];
         end
         rsp_in.total_count       = seen_ff;
         rsp_in.under_range_count = under_ff;
         rsp_in.over_range_count  = over_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         cur_ff       <= LEVEL_UNSTABLE;
         cnt_ff       <= '0;
         sum_ff       <= '0;
         done_ff      <= '0;
         seen_ff      <= '0;
         under_ff     <= '0;
         over_ff      <= '0;
         idx_ff       <= '0;
         launched_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < LEVELS; k++) begin
            cap_sum_ff[k] <= '0;
            cap_cnt_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         cnt_ff       <= cnt_in;
         sum_ff       <= sum_in;
         done_ff      <= done_in;
         seen_ff      <= seen_in;
         under_ff     <= under_in;
         over_ff      <= over_in;
         idx_ff       <= idx_in;
         launched_ff  <= launched_in;
         rsp_valid_ff <= rsp_valid_in;
         cap_sum_ff   <= cap_sum_in;
         cap_cnt_ff   <= cap_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mean_ff <= mean_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp             = rsp_ff;
   assign status.dividing = (state_ff == ST_DIV);
   assign status.emitting = (state_ff == ST_EMIT);

endmodule

// File: rtl/plateau_level_detector.sv
// Top level of the plateau level detector: configuration, front, queue, back, divider.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------------
//  req     | in        | req_valid / req_stall  | req_sample, req_last
//  rsp     | out       | rsp_valid / rsp_stall  | status, flags, three means, counters
//  csr     | in        | csr_valid / csr_ready  | csr_index, csr_wdata
//
//  One sample per cycle is taken into a four-entry queue while it is not full, and is
//  tracked by the back end at one entry per cycle while it is tracking runs.
//  On a sample marked last the back end holds the queue: three divisions (load, 48
//  steps of one result bit, collect) in the shared serial divider, then the load of
//  the report, which waits while an earlier report is still held.
//  The report then waits in the output register; the back end resumes once it is loaded.
//  Reset is synchronous, active high, and clears run state, captures and counters.
//  A full queue raises req_stall; rsp_stall holds the report in place.
`timescale 1ns / 1ps

module plateau_level_detector #(
   parameter int SAMPLE_BITS    = pld_pkg::SAMPLE_BITS_DEFAULT,
   parameter int RUN_COUNT_BITS = pld_pkg::RUN_COUNT_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [SAMPLE_BITS-1:0]        req_sample,
   input  logic                                 req_last,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_status,
   output logic [pld_pkg::LEVELS-1:0]           rsp_done_flags,
   output logic signed [pld_pkg::MEAN_BITS-1:0] rsp_mean_level_0,
   output logic signed [pld_pkg::MEAN_BITS-1:0] rsp_mean_level_1,
   output logic signed [pld_pkg::MEAN_BITS-1:0] rsp_mean_level_2,
   output logic [pld_pkg::TALLY_BITS-1:0]       rsp_total_count,
   output logic [pld_pkg::TALLY_BITS-1:0]       rsp_under_range_count,
   output logic [pld_pkg::TALLY_BITS-1:0]       rsp_over_range_count,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pld_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [pld_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   import pld_pkg::*;

   `include "plateau_level_detector_assert.svh"

   localparam int ENTRY_BITS = SAMPLE_BITS + $bits(meta_type);

   cfg_type                    cfg_ff, cfg_in;
   meta_type                   front_meta;
   meta_type                   q_meta;
   logic                       q_push, q_pop, q_valid, q_full;
   logic [ENTRY_BITS-1:0]      q_wdata, q_rdata;
   logic signed [SAMPLE_BITS-1:0] q_sample;
   div_ctl_type                div_ctl;
   div_stat_type               div_stat;
   logic [NUM_BITS-1:0]        div_numer, div_quotient;
   logic [RUN_COUNT_BITS-1:0]  div_denom;
   bk_status_type              bk_stat;
   rsp_type                    rsp;

   // configuration registers, always ready
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_REF_LEVEL_0:      cfg_in.ref_level[0]     = csr_wdata[REF_BITS-1:0];
            CSR_REF_LEVEL_1:      cfg_in.ref_level[1]     = csr_wdata[REF_BITS-1:0];
            CSR_REF_LEVEL_2:      cfg_in.ref_level[2]     = csr_wdata[REF_BITS-1:0];
            CSR_BAND_HALF_WIDTH:  cfg_in.band_half_width  = csr_wdata[HALF_BITS-1:0];
            CSR_STABLE_COUNT_MIN: cfg_in.stable_count_min = csr_wdata[MIN_BITS-1:0];
            CSR_RANGE_FLOOR:      cfg_in.range_floor      = csr_wdata[REF_BITS-1:0];
            CSR_RANGE_CEILING:    cfg_in.range_ceiling    = csr_wdata[REF_BITS-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ref_level        <= '0;
         cfg_ff.band_half_width  <= '0;
         cfg_ff.stable_count_min <= '0;
         cfg_ff.range_floor      <= {1'b1, {(REF_BITS-1){1'b0}}};
         cfg_ff.range_ceiling    <= {1'b0, {(REF_BITS-1){1'b1}}};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // classify incoming samples
   pld_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_sample (req_sample),
      .req_last   (req_last),
      .cfg        (cfg_ff),
      .q_full     (q_full),
      .q_push     (q_push),
      .meta       (front_meta)
   );

   assign q_wdata = {req_sample, front_meta};

   pld_queue #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .rdata (q_rdata),
      .valid (q_valid),
      .full  (q_full)
   );

   assign q_sample = q_rdata[ENTRY_BITS-1 -: SAMPLE_BITS];
   assign q_meta   = q_rdata[$bits(meta_type)-1:0];

   // track runs and build the report
   pld_back #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .RUN_COUNT_BITS (RUN_COUNT_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .q_valid      (q_valid),
      .q_sample     (q_sample),
      .q_meta       (q_meta),
      .q_pop        (q_pop),
      .div_ctl      (div_ctl),
      .div_numer    (div_numer),
      .div_denom    (div_denom),
      .div_quotient (div_quotient),
      .div_stat     (div_stat),
      .status       (bk_stat),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp          (rsp)
   );

   pld_div #(
      .DEN_BITS (RUN_COUNT_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .numer    (div_numer),
      .denom    (div_denom),
      .quotient (div_quotient),
      .stat     (div_stat)
   );

   // unpack the report onto the result ports
   assign rsp_status            = rsp.status;
   assign rsp_done_flags        = rsp.done_flags;
   assign rsp_mean_level_0      = rsp.mean[0];
   assign rsp_mean_level_1      = rsp.mean[1];
   assign rsp_mean_level_2      = rsp.mean[2];
   assign rsp_total_count       = rsp.total_count;
   assign rsp_under_range_count = rsp.under_range_count;
   assign rsp_over_range_count  = rsp.over_range_count;

   // checks across front, queue and back
   `PLD_ASSERT_IMP(a_pop_has_data, q_pop, q_valid)
   `PLD_ASSERT_IMP(a_no_pop_in_report, (bk_stat.dividing || bk_stat.emitting), !q_pop)
   `PLD_ASSERT_IMP(a_status_matches_flags, rsp_valid, (rsp_status == (rsp_done_flags != 3'b111)))
   `PLD_ASSERT_NXT(a_reset_clears_rsp, reset, !rsp_valid)

endmodule
